// File: design/ltd_pkg.sv
// Shared constants and types for the LRU tag directory.
package ltd_pkg;

    localparam int ENTRIES  = 16;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W    = 64;
    localparam int STAMP_W  = 31;
    localparam int SLOT_W   = 4;
    localparam int GRP_SIZE = 4;
    localparam int NGRP     = (ENTRIES + GRP_SIZE - 1) / GRP_SIZE;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [STAMP_W-1:0] stamp_t;
    typedef logic [SLOT_W-1:0]  slot_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic compare;
        logic commit;
    } ltd_cmd_t;

endpackage

// File: design/ltd_if.sv
// Request and response channel interfaces of the LRU tag directory.
interface ltd_req_if
    import ltd_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   kind;
    key_t   key;
    stamp_t stamp;

    modport source (output valid, kind, key, stamp, input ready);
    modport sink   (input valid, kind, key, stamp, output ready);
endinterface

interface ltd_rsp_if
    import ltd_pkg::*;
;
    logic  valid;
    logic  ready;
    logic  hit;
    slot_t slot;
    logic  evicted;

    modport source (output valid, hit, slot, evicted, input ready);
    modport sink   (input valid, hit, slot, evicted, output ready);
endinterface

// File: design/ltd_ctrl.sv
// Controller state machine of the LRU tag directory.
module ltd_ctrl
    import ltd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output ltd_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_WR   = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       commit;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;

    // A result may be written once the output register is empty or is being taken.
    assign commit = (state_reg == ST_WR) && (!out_valid_reg || rsp_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign cmd.capture = req_valid && req_ready;
    assign cmd.compare = (state_reg == ST_CMP);
    assign cmd.commit  = commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: design/ltd_datapath.sv
// Entry store, key compare, victim search and result register of the directory.
module ltd_datapath
    import ltd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  ltd_cmd_t cmd,
    input  logic     in_kind,
    input  key_t     in_key,
    input  stamp_t   in_stamp,
    output logic     out_hit,
    output slot_t    out_slot,
    output logic     out_evicted
);

    logic   valid_reg [ENTRIES];
    key_t   key_reg   [ENTRIES];
    stamp_t stamp_reg [ENTRIES];

    logic   kind_reg;
    key_t   rkey_reg;
    stamp_t rstamp_reg;

    logic [ENTRIES-1:0] match_reg, match_next;
    idx_t   grp_idx_reg   [NGRP];
    stamp_t grp_stamp_reg [NGRP];
    idx_t   grp_idx_next  [NGRP];
    stamp_t grp_stamp_next[NGRP];

    logic   hit_reg, evicted_reg;
    slot_t  slot_reg;

    logic   any_match, any_free;
    idx_t   match_idx, free_idx, lru_idx, victim_idx;
    stamp_t lru_stamp;

    // First stage: per-entry key compare and the minimum stamp within each group.
    always_comb
    begin
        for (int e = 0; e < ENTRIES; e++)
        begin
            match_next[e] = valid_reg[e] && (key_reg[e] == rkey_reg);
        end
        for (int g = 0; g < NGRP; g++)
        begin
            grp_idx_next[g]   = IDX_W'(g * GRP_SIZE);
            grp_stamp_next[g] = stamp_reg[g * GRP_SIZE];
            for (int j = 1; j < GRP_SIZE; j++)
            begin
                if ((g * GRP_SIZE + j) < ENTRIES)
                begin
                    if (stamp_reg[g * GRP_SIZE + j] < grp_stamp_next[g])
                    begin
                        grp_idx_next[g]   = IDX_W'(g * GRP_SIZE + j);
                        grp_stamp_next[g] = stamp_reg[g * GRP_SIZE + j];
                    end
                end
            end
        end
    end

    // Second stage: lowest matching entry, lowest free entry, oldest group winner.
    always_comb
    begin
        any_match = 1'b0;
        match_idx = '0;
        any_free  = 1'b0;
        free_idx  = '0;
        for (int e = ENTRIES - 1; e >= 0; e--)
        begin
            if (match_reg[e])
            begin
                any_match = 1'b1;
                match_idx = IDX_W'(e);
            end
            if (!valid_reg[e])
            begin
                any_free = 1'b1;
                free_idx = IDX_W'(e);
            end
        end
        lru_idx   = grp_idx_reg[0];
        lru_stamp = grp_stamp_reg[0];
        for (int g = 1; g < NGRP; g++)
        begin
            if (grp_stamp_reg[g] < lru_stamp)
            begin
                lru_idx   = grp_idx_reg[g];
                lru_stamp = grp_stamp_reg[g];
            end
        end
        victim_idx = any_free ? free_idx : lru_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < ENTRIES; e++)
            begin
                valid_reg[e] <= 1'b0;
            end
        end
        else if (cmd.commit && (kind_reg == KIND_INSERT))
        begin
            valid_reg[victim_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg   <= in_kind;
            rkey_reg   <= in_key;
            rstamp_reg <= in_stamp;
        end
        if (cmd.compare)
        begin
            match_reg <= match_next;
            for (int g = 0; g < NGRP; g++)
            begin
                grp_idx_reg[g]   <= grp_idx_next[g];
                grp_stamp_reg[g] <= grp_stamp_next[g];
            end
        end
        if (cmd.commit)
        begin
            if (kind_reg == KIND_INSERT)
            begin
                key_reg[victim_idx]   <= rkey_reg;
                stamp_reg[victim_idx] <= rstamp_reg;
                hit_reg               <= 1'b0;
                slot_reg              <= SLOT_W'(victim_idx);
                evicted_reg           <= !any_free;
            end
            else
            begin
                if (any_match)
                begin
                    stamp_reg[match_idx] <= rstamp_reg;
                end
                hit_reg     <= any_match;
                slot_reg    <= any_match ? SLOT_W'(match_idx) : '0;
                evicted_reg <= 1'b0;
            end
        end
    end

    assign out_hit     = hit_reg;
    assign out_slot    = slot_reg;
    assign out_evicted = evicted_reg;

endmodule

// File: design/lru_tag_directory.sv
// Top level of the LRU tag directory.
// A fully associative directory of sixteen entries. A lookup request returns the lowest
// matching valid entry and refreshes its stamp; an insert request takes the lowest free
// entry, or else the entry with the smallest stamp, and reports whether it evicted one.
// After a request is accepted, the parallel key compare and the per-group minimum stamp search
// are registered; then the victim is picked, the entry updated and the result register loaded,
// which waits while the previous result is still held unaccepted. A new request is accepted in
// the cycle after the previous result is loaded, so the directory takes no new request while one
// is in flight. Valid marks clear at reset; no clearing pass is needed.
module lru_tag_directory
    import ltd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    ltd_req_if.sink    req,
    ltd_rsp_if.source  rsp
);

    ltd_cmd_t cmd;

    ltd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    ltd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_kind     (req.kind),
        .in_key      (req.key),
        .in_stamp    (req.stamp),
        .out_hit     (rsp.hit),
        .out_slot    (rsp.slot),
        .out_evicted (rsp.evicted)
    );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the LRU tag directory: random lookup and insert traffic against a predictor.
module tb_top;
    import ltd_pkg::*;

    localparam stamp_t STAMP_MAX      = '1;
    localparam int     POOL_SIZE      = 24;
    localparam int     RANDOM_ITEMS   = 950;
    localparam int     HOLD_AFTER     = 300;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     DRAIN_AT       = 480;
    localparam int     SETTLE_CYCLES  = 20;
    localparam int     MAX_PRINTED    = 30;

    typedef struct {
        logic   kind;
        key_t   key;
        stamp_t stamp;
        bit     drain;
    } dir_req_t;

    typedef struct packed {
        logic  hit;
        slot_t slot;
        logic  evicted;
    } dir_rsp_t;

    logic clk;
    logic rst_n;

    ltd_req_if req_ch ();
    ltd_rsp_if rsp_ch ();

    lru_tag_directory uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predicted directory contents.
    logic   dir_valid [ENTRIES];
    key_t   dir_key   [ENTRIES];
    stamp_t dir_stamp [ENTRIES];

    dir_req_t pending_reqs [$];
    dir_rsp_t expected_rsps [$];
    key_t     key_pool [POOL_SIZE];

    int mismatch_cnt;
    int accepted_cnt;
    int burst_left;
    int gap_left;
    int hold_left;
    bit hold_done;
    int ready_cycle;

    function automatic dir_rsp_t directory_update(logic kind, key_t key, stamp_t stamp);
        dir_rsp_t r;
        int       victim;
        stamp_t   oldest;
        bit       found;
        r = '0;
        found = 1'b0;
        if (kind == KIND_LOOKUP)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (!found && dir_valid[i] && dir_key[i] == key)
                begin
                    found = 1'b1;
                    dir_stamp[i] = stamp;
                    r.hit = 1'b1;
                    r.slot = slot_t'(i);
                end
            end
        end
        else
        begin
            // First free entry wins; otherwise the oldest stamp, lowest index on ties.
            victim = 0;
            oldest = STAMP_MAX;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (!found)
                begin
                    if (!dir_valid[i])
                    begin
                        victim = i;
                        found = 1'b1;
                    end
                    else if (dir_stamp[i] < oldest)
                    begin
                        victim = i;
                        oldest = dir_stamp[i];
                    end
                end
            end
            r.evicted = dir_valid[victim];
            dir_valid[victim] = 1'b1;
            dir_key[victim] = key;
            dir_stamp[victim] = stamp;
            r.slot = slot_t'(victim);
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_PRINTED)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic add_request(logic kind, key_t key, stamp_t stamp, bit drain);
        dir_req_t r;
        r.kind = kind;
        r.key = key;
        r.stamp = stamp;
        r.drain = drain;
        pending_reqs.push_back(r);
    endtask

    function automatic stamp_t pick_stamp();
        int sel;
        sel = $urandom_range(9, 0);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return STAMP_MAX;
        else if (sel <= 4)
            return stamp_t'($urandom_range(15, 0));
        else
            return stamp_t'($urandom_range(32'h7fffffff, 0));
    endfunction

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_LOOKUP;
        req_ch.key = '0;
        req_ch.stamp = '0;
        rsp_ch.ready = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #3000000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        dir_req_t nxt;
        logic     fire;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.kind <= KIND_LOOKUP;
            req_ch.key <= '0;
            req_ch.stamp <= '0;
            burst_left <= 0;
            gap_left <= 0;
            accepted_cnt <= 0;
        end
        else
        begin
            fire = req_ch.valid && req_ch.ready;
            if (fire)
            begin
                expected_rsps.push_back(directory_update(req_ch.kind, req_ch.key,
                                                         req_ch.stamp));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (req_ch.valid && !fire)
            begin
                // Request still offered; hold it steady.
            end
            else if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                req_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain && expected_rsps.size() != 0))
            begin
                nxt = pending_reqs.pop_front();
                req_ch.kind <= nxt.kind;
                req_ch.key <= nxt.key;
                req_ch.stamp <= nxt.stamp;
                req_ch.valid <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left <= ($urandom_range(7, 0) == 0) ? $urandom_range(80, 30)
                                                              : $urandom_range(12, 0);
                    gap_left <= ($urandom_range(3, 0) == 0) ? $urandom_range(30, 8)
                                                            : $urandom_range(5, 1);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off, started once enough requests have gone in.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accepted_cnt >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Receiver stalls follow one of four modes, chosen by a free-running cycle counter.
    always @(posedge clk or negedge rst_n)
    begin : rsp_ready_gen
        logic want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            ready_cycle <= 0;
        end
        else
        begin
            case ((ready_cycle / 64) % 4)
                0: want = 1'b1;
                1: want = 1'($urandom_range(1, 0));
                2: want = (ready_cycle % 4) == 0;
                default: want = $urandom_range(3, 0) != 0;
            endcase
            ready_cycle <= ready_cycle + 1;
            rsp_ch.ready <= want && (hold_left == 0);
        end
    end

    // Response monitor.
    always @(posedge clk)
    begin : rsp_monitor
        dir_rsp_t exp_rsp;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                report_mismatch("response arrived with no request outstanding");
            end
            else
            begin
                exp_rsp = expected_rsps.pop_front();
                if (rsp_ch.hit !== exp_rsp.hit)
                    report_mismatch($sformatf("hit %b, expected %b",
                                              rsp_ch.hit, exp_rsp.hit));
                if (rsp_ch.slot !== exp_rsp.slot)
                    report_mismatch($sformatf("slot %0d, expected %0d",
                                              rsp_ch.slot, exp_rsp.slot));
                if (rsp_ch.evicted !== exp_rsp.evicted)
                    report_mismatch($sformatf("evicted %b, expected %b",
                                              rsp_ch.evicted, exp_rsp.evicted));
            end
        end
    end

    initial
    begin : stimulus
        logic kind;
        key_t key;
        mismatch_cnt = 0;
        for (int i = 0; i < ENTRIES; i++)
            dir_valid[i] = 1'b0;
        // Low bits keep every pool key distinct and away from all zeros and all ones.
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            key_pool[i] = {$urandom, $urandom};
            key_pool[i][5:0] = 6'(i + 1);
        end

        // Lookup on an empty directory misses.
        add_request(KIND_LOOKUP, '0, STAMP_MAX, 1'b0);
        // Fill every entry with the largest stamp, extreme keys first.
        add_request(KIND_INSERT, '0, STAMP_MAX, 1'b0);
        add_request(KIND_INSERT, '1, STAMP_MAX, 1'b0);
        for (int i = 2; i < ENTRIES; i++)
            add_request(KIND_INSERT, key_pool[i], STAMP_MAX, 1'b0);
        // Full directory with all stamps at the maximum evicts entry 0.
        add_request(KIND_INSERT, key_pool[0], STAMP_MAX, 1'b0);
        // Two entries refreshed to stamp zero: the lower index loses the tie.
        add_request(KIND_LOOKUP, '1, '0, 1'b0);
        add_request(KIND_LOOKUP, key_pool[3], '0, 1'b0);
        add_request(KIND_INSERT, key_pool[5], stamp_t'(5), 1'b0);
        // The evicted key now misses, and the duplicate hits the lower entry.
        add_request(KIND_LOOKUP, '1, stamp_t'(9), 1'b0);
        add_request(KIND_LOOKUP, key_pool[5], stamp_t'(1), 1'b0);
        add_request(KIND_LOOKUP, key_pool[0], '0, 1'b1);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(9, 0) == 0)
            begin
                kind = 1'($urandom_range(1, 0));
                key = {$urandom, $urandom};
            end
            else
            begin
                kind = ($urandom_range(9, 0) < 6) ? KIND_LOOKUP : KIND_INSERT;
                key = key_pool[$urandom_range(POOL_SIZE - 1, 0)];
            end
            add_request(kind, key, pick_stamp(),
                        n == DRAIN_AT || $urandom_range(99, 0) == 0);
        end

        while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
